FILE: hw/rtl/sipc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sipc_pkg
// Shared types, constants and the parallel CRC32C helpers of the shard index
// packer.
// ----------------------------------------------------------------------------
package sipc_pkg;

  localparam int unsigned CHUNK_COUNT     = 512;
  localparam int unsigned MAX_CHUNK_BYTES = 8192;

  localparam int unsigned BYTES_W = 14;
  localparam int unsigned OFF_W   = 23;
  localparam int unsigned CRC_W   = 32;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned MSG_W   = 2 * ENTRY_W;
  localparam int unsigned COL_N   = CRC_W + MSG_W;
  localparam int unsigned POS_W   = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;

  localparam int unsigned ENTRY_BYTES   = 16;
  localparam int unsigned TRAILER_BYTES = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F63B78;
  localparam logic [CRC_W-1:0] CRC_SEED = 32'hFFFFFFFF;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CHUNK_COUNT - 1);
  localparam logic [OFF_W-1:0] TOTAL_BASE =
    OFF_W'((CHUNK_COUNT * ENTRY_BYTES + TRAILER_BYTES) % (2 ** OFF_W));
  localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(MAX_CHUNK_BYTES);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // one classified chunk request between front and back
  typedef struct packed {
    logic               empty;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } sipc_item_t;

  typedef logic [CRC_W-1:0] crc_cols_t [COL_N];

  // effect of each state bit and each message bit on the crc after 128 bits,
  // evaluated at elaboration
  function automatic crc_cols_t crc_cols_f();
    crc_cols_t        cols;
    logic [CRC_W-1:0] c;
    logic [MSG_W-1:0] m;
    logic             fb;
    for (int j = 0; j < COL_N; j++) begin
      if (j < CRC_W) begin
        c = CRC_W'(1) << j;
        m = '0;
      end else begin
        c = '0;
        m = MSG_W'(1) << (j - CRC_W);
      end
      for (int i = 0; i < MSG_W; i++) begin
        fb = c[0] ^ m[i];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      cols[j] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols_f();

  // msg is {length, offset}: bytes little endian, bits lsb first
  function automatic logic [CRC_W-1:0] crc_next_f(input logic [CRC_W-1:0] crc,
                                                  input logic [MSG_W-1:0] msg);
    logic [COL_N-1:0] v;
    logic [CRC_W-1:0] r;
    v = {msg, crc};
    r = '0;
    for (int j = 0; j < COL_N; j++) begin
      if (v[j]) begin
        r = r ^ CRC_COLS[j];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sipc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sipc_front
// Accepts chunk requests, saturates the byte count and tags the last chunk
// of each shard.
// ----------------------------------------------------------------------------
module sipc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          chunk_empty_i,
  input  wire logic [sipc_pkg::BYTES_W-1:0]  chunk_bytes_i,
  input  wire logic                          fifo_full_i,
  output logic                               push_o,
  output sipc_pkg::sipc_item_t               item_o
);

  logic [sipc_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       last;

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;
  assign last       = (pos_q >= sipc_pkg::LAST_POS);

  always_comb begin
    item_o.empty = chunk_empty_i;
    item_o.last  = last;
    if (32'(chunk_bytes_i) > 32'(sipc_pkg::MAX_CHUNK_BYTES)) begin
      item_o.bytes = sipc_pkg::MAX_BYTES;
    end else begin
      item_o.bytes = chunk_bytes_i;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = last ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sipc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sipc_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module sipc_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sipc_pkg::sipc_item_t  item_i,
  output logic                       full_o,
  output logic                       valid_o,
  input  wire logic                  pop_i,
  output sipc_pkg::sipc_item_t       item_o
);

  sipc_pkg::sipc_item_t             mem_q [sipc_pkg::FIFO_DEPTH];
  logic [sipc_pkg::PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [sipc_pkg::CNT_W-1:0]       count_q, count_d;

  assign full_o  = (count_q == sipc_pkg::CNT_W'(sipc_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sipc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sipc_back
// Builds each index entry, runs the offset and the CRC32C over the entry
// bytes, and holds the result in the output register.
// ----------------------------------------------------------------------------
module sipc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  input  wire sipc_pkg::sipc_item_t          item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sipc_pkg::ENTRY_W-1:0]       entry_offset_o,
  output logic [sipc_pkg::ENTRY_W-1:0]       entry_length_o,
  output logic [sipc_pkg::CRC_W-1:0]         index_crc_o,
  output logic [sipc_pkg::OFF_W-1:0]         shard_total_bytes_o,
  output logic                               last_chunk_o
);

  logic [sipc_pkg::OFF_W-1:0]   off_q, off_d, tot_q, tot_d, off_adv, tot_adv;
  logic [sipc_pkg::CRC_W-1:0]   crc_q, crc_d, crc_calc;
  logic [sipc_pkg::ENTRY_W-1:0] off_field, len_field;
  logic                         out_valid_q, load;

  assign load        = item_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load;
  assign out_valid_o = out_valid_q;

  always_comb begin
    if (item_i.empty) begin
      off_field = '1;
      len_field = '1;
      off_adv   = off_q;
      tot_adv   = tot_q;
    end else begin
      off_field = sipc_pkg::ENTRY_W'(off_q);
      len_field = sipc_pkg::ENTRY_W'(item_i.bytes);
      off_adv   = off_q + sipc_pkg::OFF_W'(item_i.bytes);
      // total is kept as offset plus index and trailer size
      tot_adv   = tot_q + sipc_pkg::OFF_W'(item_i.bytes);
    end
    crc_calc = sipc_pkg::crc_next_f(crc_q, {len_field, off_field});
  end

  always_comb begin
    off_d = off_q;
    tot_d = tot_q;
    crc_d = crc_q;
    if (load) begin
      if (item_i.last) begin
        off_d = '0;
        tot_d = sipc_pkg::TOTAL_BASE;
        crc_d = sipc_pkg::CRC_SEED;
      end else begin
        off_d = off_adv;
        tot_d = tot_adv;
        crc_d = crc_calc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      tot_q       <= sipc_pkg::TOTAL_BASE;
      crc_q       <= sipc_pkg::CRC_SEED;
      out_valid_q <= 1'b0;
    end else begin
      off_q <= off_d;
      tot_q <= tot_d;
      crc_q <= crc_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_offset_o      <= off_field;
      entry_length_o      <= len_field;
      last_chunk_o        <= item_i.last;
      index_crc_o         <= item_i.last ? (crc_calc ^ sipc_pkg::CRC_SEED) : '0;
      shard_total_bytes_o <= item_i.last ? tot_adv : '0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/shard_index_packer_crc32c_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shard_index_packer_crc32c_top
// Shard index packer: per-chunk index entries with a CRC32C trailer.
// ----------------------------------------------------------------------------
// Takes one chunk request per cycle while in_stall_o is low (empty flag and
// byte count, in raster order) and returns one index entry per request once
// it has passed the request queue and the back stage's output register; with
// no stall at the output the sustained rate is one request per cycle. The
// whole 16-byte entry goes through a parallel CRC32C xor network in the back
// stage. A two-entry queue separates the input side from the result register,
// so either side may stall without losing a request. The entry marked
// last_chunk carries the final index CRC and the total shard size; the block
// then starts the next shard from its reset state.
module shard_index_packer_crc32c_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          chunk_empty_i,
  input  wire logic [sipc_pkg::BYTES_W-1:0]  chunk_bytes_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sipc_pkg::ENTRY_W-1:0]       entry_offset_o,
  output logic [sipc_pkg::ENTRY_W-1:0]       entry_length_o,
  output logic [sipc_pkg::CRC_W-1:0]         index_crc_o,
  output logic [sipc_pkg::OFF_W-1:0]         shard_total_bytes_o,
  output logic                               last_chunk_o
);

  sipc_pkg::sipc_item_t push_item, pop_item;
  logic                 push, pop, fifo_full, fifo_valid;

  sipc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .chunk_empty_i (chunk_empty_i),
    .chunk_bytes_i (chunk_bytes_i),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  sipc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .item_o  (pop_item)
  );

  sipc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .item_valid_i        (fifo_valid),
    .item_i              (pop_item),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .entry_offset_o      (entry_offset_o),
    .entry_length_o      (entry_length_o),
    .index_crc_o         (index_crc_o),
    .shard_total_bytes_o (shard_total_bytes_o),
    .last_chunk_o        (last_chunk_o)
  );

  // trailer fields are zero except on the last entry
  a_trailer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_chunk_o |-> index_crc_o == '0 && shard_total_bytes_o == '0)
    else $error("trailer fields set on a non-last entry");

  // a non-empty last entry ends, plus the index and trailer size, at the shard total
  a_total_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_chunk_o && entry_length_o != '1 |->
      shard_total_bytes_o == sipc_pkg::OFF_W'(entry_offset_o + entry_length_o
                                               + 64'(sipc_pkg::TOTAL_BASE)))
    else $error("shard total does not match last entry");

  // queue never takes a request while full and never pops while empty
  a_fifo_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_full) && !(pop && !fifo_valid))
    else $error("request queue overflow or underflow");

endmodule
`default_nettype wire
